// ===== sv/injected_command_echo_matcher_defines.svh =====
// assertion macros for the echo matcher
`ifndef INJECTED_COMMAND_ECHO_MATCHER_DEFINES_SVH
`define INJECTED_COMMAND_ECHO_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS

// checked property, disabled while reset is asserted
`define ICEM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property, also held during reset
`define ICEM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ICEM_ASSERT(label, clk, rst_n, prop, msg)

`define ICEM_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== sv/icem_pkg.sv =====
package icem_pkg;

    // default ring depth and register reset value
    localparam int          RING_SLOTS_DEFAULT  = 64;
    localparam logic [31:0] STALE_TIMEOUT_RESET = 32'd2000000;

    // reported source of an observed event
    typedef enum logic [1:0] {
        SRC_NONE     = 2'd0,
        SRC_REMOTE   = 2'd1,
        SRC_PHYSICAL = 2'd2
    } src_t;

    // input item modes
    localparam logic MODE_RESERVE = 1'b0;
    localparam logic MODE_OBSERVE = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DONE
    } state_t;

    // one input transaction
    typedef struct packed {
        logic               mode;
        logic [15:0]        control_id;
        logic [7:0]         operation;
        logic [7:0]         channel;
        logic signed [31:0] int_value;
        logic [31:0]        float_word;
        logic signed [31:0] aux_value;
        logic [63:0]        now_us;
        logic               msg_thread;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic [1:0] source;
        logic       busy_res;
    } result_t;

    // one ring slot
    typedef struct packed {
        logic [31:0] key_op_chan;
        logic [31:0] int_value;
        logic [31:0] float_word;
        logic [31:0] aux_value;
        logic [63:0] time_us;
        logic        emitted;
    } entry_t;

endpackage

// ===== sv/icem_ring.sv =====
module icem_ring #(
    parameter int RING_SLOTS = icem_pkg::RING_SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(RING_SLOTS)-1:0] wr_addr,
    input  icem_pkg::entry_t              wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(RING_SLOTS)-1:0] rd_addr,
    output icem_pkg::entry_t              rd_data
);
    import icem_pkg::*;

    entry_t slot_mem [RING_SLOTS];
    entry_t rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/icem_ctrl.sv =====
module icem_ctrl #(
    parameter int RING_SLOTS = icem_pkg::RING_SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  icem_pkg::item_t               item,
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [31:0]                   cfg_data,
    // result handoff to the output register
    output logic                          res_valid,
    input  logic                          res_ready,
    output icem_pkg::result_t             res,
    // ring memory
    output logic                          wr_en,
    output logic [$clog2(RING_SLOTS)-1:0] wr_addr,
    output icem_pkg::entry_t              wr_data,
    output logic                          rd_en,
    output logic [$clog2(RING_SLOTS)-1:0] rd_addr,
    input  icem_pkg::entry_t              rd_data
);
    import icem_pkg::*;

    `include "injected_command_echo_matcher_defines.svh"

    localparam int IDX_W = $clog2(RING_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_SLOTS - 1);

    state_t      state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [31:0] timeout_reg;
    item_t       item_reg;
    result_t     res_reg, res_next;

    logic             item_take;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] tail_inc;
    logic             ring_empty;
    logic [63:0]      age;
    logic             stale;
    logic             match;
    logic [1:0]       miss_src;

    assign item_take  = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;

    // ring index arithmetic with wrap at any depth
    assign head_inc   = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc   = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign ring_empty = (head_reg == tail_reg);

    // head entry checks against the held item
    assign age   = item_reg.now_us - rd_data.time_us;
    assign stale = (age > {32'd0, timeout_reg});
    assign match = (rd_data.key_op_chan == {item_reg.control_id, item_reg.operation,
                                            item_reg.channel})
                && (rd_data.int_value  == $unsigned(item_reg.int_value))
                && (rd_data.float_word == item_reg.float_word)
                && (rd_data.aux_value  == $unsigned(item_reg.aux_value));
    assign miss_src = item_reg.msg_thread ? SRC_PHYSICAL : SRC_NONE;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    if (item.mode == MODE_OBSERVE && !ring_empty)
                        state_next = ST_CHECK;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_CHECK:
            begin
                if (!(stale && head_inc != tail_reg))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = head_reg;
        wr_en     = 1'b0;
        wr_addr   = tail_reg;
        wr_data   = '{key_op_chan: {item.control_id, item.operation, item.channel},
                      int_value:   $unsigned(item.int_value),
                      float_word:  item.float_word,
                      aux_value:   $unsigned(item.aux_value),
                      time_us:     item.now_us,
                      emitted:     1'b0};
        head_next = head_reg;
        tail_next = tail_reg;
        res_next  = res_reg;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    res_next = '{source: SRC_NONE, busy_res: 1'b0};
                    if (item.mode == MODE_RESERVE)
                    begin
                        // append unless that would fill the last free slot
                        if (tail_inc == head_reg)
                        begin
                            res_next.busy_res = 1'b1;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            tail_next = tail_inc;
                        end
                    end
                    else if (ring_empty)
                    begin
                        res_next.source = item.msg_thread ? SRC_PHYSICAL : SRC_NONE;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                // address the slot after head, read it only while the stale walk goes on
                rd_addr = head_inc;
                if (stale)
                begin
                    head_next = head_inc;
                    rd_en     = (head_inc != tail_reg);
                    res_next.source = miss_src;
                end
                else if (match && rd_data.emitted)
                begin
                    head_next       = head_inc;
                    res_next.source = SRC_NONE;
                end
                else if (match)
                begin
                    // mark emitted, pop only on the message thread
                    wr_en           = 1'b1;
                    wr_addr         = head_reg;
                    wr_data         = rd_data;
                    wr_data.emitted = 1'b1;
                    if (item_reg.msg_thread)
                        head_next = head_inc;
                    res_next.source = SRC_REMOTE;
                end
                else
                begin
                    res_next.source = miss_src;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign res = res_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            timeout_reg <= STALE_TIMEOUT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            if (cfg_valid && cfg_ready)
                timeout_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
        res_reg <= res_next;
    end

    `ICEM_ASSERT(a_head_moves_in_check, clk, rst_n, (state_reg != ST_CHECK) |=> (head_reg == $past(head_reg)), "head moved outside the head check")
    `ICEM_ASSERT(a_tail_moves_on_accept, clk, rst_n, !(item_take && item.mode == MODE_RESERVE) |=> (tail_reg == $past(tail_reg)), "tail moved without a reserve")
    `ICEM_ASSERT(a_busy_keeps_tail, clk, rst_n, (res_valid && res.busy_res) |-> (tail_reg == head_reg - 1'b1 || (head_reg == '0 && tail_reg == LAST_IDX)), "busy reported on a ring that is not full")
    `ICEM_ASSERT(a_busy_no_source, clk, rst_n, res_valid |-> !(res.busy_res && res.source != SRC_NONE), "busy result carries a source")
    `ICEM_ASSERT_ALWAYS(a_result_blocks_input, clk, res_valid |-> item_stall, "result offered while input open")

endmodule

// ===== sv/injected_command_echo_matcher.sv =====
// Echo matcher for remotely injected control commands. A reserve transaction
// (mode 0) appends the command with its timestamp to a ring of RING_SLOTS - 1
// usable slots held in one synchronous memory, and answers busy_res = 1 when
// the ring is full. An observe transaction (mode 1) drops head entries older
// than stale_timeout_us, then compares the head with the observed control and
// reports source none, remote or physical. One transaction is in work at a
// time: a reserve or an observe on an empty ring gives its result directly;
// an observe on a non-empty ring examines head entries one at a time (every
// stale entry dropped, and the live entry the walk stops at), each read from
// the ring memory's registered read port. The result sits in an output
// register, so the next transaction is taken while a result still waits.
// The user writes stale_timeout_us through cfg_valid/cfg_data only while no
// transaction is in work, unenforced by the block; cfg_ready is always high.
module injected_command_echo_matcher #(
    parameter int RING_SLOTS = icem_pkg::RING_SLOTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  icem_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output icem_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data
);
    import icem_pkg::*;

    localparam int IDX_W = $clog2(RING_SLOTS);

    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             result_valid_reg;
    result_t          result_reg;

    icem_ctrl #(
        .RING_SLOTS (RING_SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    icem_ring #(
        .RING_SLOTS (RING_SLOTS)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register takes a new result when empty or being drained
    assign res_ready = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            result_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            result_reg <= res;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
